### hdl/ardk_pkg.sv
`timescale 1ns / 1ps

package ardk_pkg;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE      = 2'd0,
    CFG_DERIV_DIM = 2'd1,
    CFG_JITTER    = 2'd2
  } cfg_index_e;

  localparam logic [15:0] JITTER_RESET = 16'd1759;
  localparam logic [4:0] SERIES_TERMS = 5'd24;
  localparam logic [63:0] ONE62 = 64'h4000_0000_0000_0000;

  typedef enum logic [4:0] {
    OP_NONE       = 5'd0,
    OP_CAPTURE    = 5'd1,
    OP_MUL_LOAD   = 5'd2,
    OP_MUL_STEP   = 5'd3,
    OP_ACC        = 5'd4,
    OP_DFAC       = 5'd5,
    OP_EZERO      = 5'd6,
    OP_SER_INIT   = 5'd7,
    OP_DIV_INIT   = 5'd8,
    OP_DIV_STEP   = 5'd9,
    OP_SER_ACC    = 5'd10,
    OP_SER_END    = 5'd11,
    OP_E_UPD      = 5'd12,
    OP_P_UPD      = 5'd13,
    OP_ROUND      = 5'd14,
    OP_VAL_KERNEL = 5'd15,
    OP_VAL_DERIV  = 5'd16,
    OP_FINAL      = 5'd17
  } dp_op_e;

  typedef enum logic [2:0] {
    SEL_MAG_MAG = 3'd0,
    SEL_SQ_W    = 3'd1,
    SEL_MAG_W   = 3'd2,
    SEL_T_F     = 3'd3,
    SEL_E_P     = 3'd4,
    SEL_P_P     = 3'd5,
    SEL_FM_E    = 3'd6
  } mul_sel_e;

  typedef struct packed {
    dp_op_e     op;
    mul_sel_e   sel;
    logic [1:0] step;
    logic       ser_one;
  } ctrl_cmd_t;

  typedef struct packed {
    logic cmd;
    logic in_range;
    logic deriv_hit;
    logic last;
    logic n_big;
    logic ser_one;
    logic k_last;
    logic n_lsb;
    logic mode;
  } dp_status_t;

endpackage

### hdl/ard_rbf_kernel_engine.sv
`timescale 1ns / 1ps

// Squared-exponential ARD covariance engine. One item carries one dimension of a
// point pair; command 0 loads that dimension's weight, command 1 streams the two
// coordinates. Each input transfer completes when in_valid_i is high and
// in_stall_o is low, and a result transfer when out_valid_o is high and
// out_stall_i is low. Configuration is written through cfg_we_i, cfg_index_i and
// cfg_wdata_i; the user must write it only while the block is idle, which the
// block itself does not enforce. Coordinate items use the shared 32 by 32
// multiplier, which forms each wide product from partial products, and the chosen
// derivative dimension takes one more product. A coordinate item marked last then
// evaluates the exponential: two 24-term series, each term a multiply and a
// bit-serial division to 64 quotient bits, plus up to ten power products.
// A result waits in the output register while the receiver stalls; the next item
// is accepted meanwhile, but its own result waits until that transfer completes.
// Reset clears the distance sum, the derivative factor, the clip flag, the output
// valid, mode and derivative dimension, sets jitter to 1759; weights are unset until loaded.

module ard_rbf_kernel_engine #(
  parameter int unsigned DIMS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ardk_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ardk_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            command_i,
  input  logic [3:0]                      dim_index_i,
  input  logic signed [31:0]              first_coord_i,
  input  logic signed [31:0]              second_coord_i,
  input  logic [31:0]                     weight_value_i,
  input  logic                            last_dim_i,
  input  logic                            on_diagonal_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [47:0]              kernel_value_o,
  output logic                            saturated_o
);

  ardk_pkg::ctrl_cmd_t  cmd;
  ardk_pkg::dp_status_t status;

  ardk_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ardk_datapath #(
    .DIMS(DIMS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .command_i     (command_i),
    .dim_index_i   (dim_index_i),
    .first_coord_i (first_coord_i),
    .second_coord_i(second_coord_i),
    .weight_value_i(weight_value_i),
    .last_dim_i    (last_dim_i),
    .on_diagonal_i (on_diagonal_i),
    .kernel_value_o(kernel_value_o),
    .saturated_o   (saturated_o)
  );

endmodule

### hdl/ardk_ram.sv
`timescale 1ns / 1ps

module ardk_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/ardk_datapath.sv
`timescale 1ns / 1ps

module ardk_datapath #(
  parameter int unsigned DIMS = 16,
  localparam int unsigned AW = (DIMS > 1) ? $clog2(DIMS) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ardk_pkg::ctrl_cmd_t           cmd_i,
  output ardk_pkg::dp_status_t          status_o,
  input  logic                          cfg_we_i,
  input  logic [ardk_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ardk_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                          command_i,
  input  logic [3:0]                    dim_index_i,
  input  logic signed [31:0]            first_coord_i,
  input  logic signed [31:0]            second_coord_i,
  input  logic [31:0]                   weight_value_i,
  input  logic                          last_dim_i,
  input  logic                          on_diagonal_i,
  output logic signed [47:0]            kernel_value_o,
  output logic                          saturated_o
);

  localparam logic [6:0] DimsLimit = 7'(DIMS);
  localparam logic signed [51:0] OutMax = 52'sd140737488355327;
  localparam logic signed [51:0] OutMin = -52'sd140737488355328;

  logic        mode_q, mode_d;
  logic [3:0]  deriv_dim_q, deriv_dim_d;
  logic [15:0] jitter_q, jitter_d;
  logic [63:0] sum_q, sum_d;
  logic signed [63:0] dfac_q, dfac_d;
  logic        clip_q, clip_d;

  logic        cmd_q, cmd_d, last_q, last_d, diag_q, diag_d;
  logic [3:0]  dim_q, dim_d;
  logic signed [32:0] dx_q, dx_d;
  logic [31:0] mag_q, mag_d;
  logic [63:0] a_q, a_d, b_q, b_d;
  logic [127:0] prod_q, prod_d;
  logic [63:0] t_q, t_d, pos_q, pos_d, neg_q, neg_d, e_q, e_d, p_q, p_d, quo_q, quo_d;
  logic [32:0] f_q, f_d;
  logic [4:0]  n_q, n_d, k_q, k_d, rem_q, rem_d;
  logic        ser_one_q, ser_one_d;
  logic signed [50:0] val_q, val_d;
  logic signed [47:0] kv_q, kv_d;
  logic        sat_q, sat_d;

  logic [31:0] w;
  logic        in_range_now;
  logic signed [32:0] dx_in, dx_neg;
  logic [31:0] a_part, b_part;
  logic [63:0] pp;
  logic [127:0] pp_shift;
  logic [64:0] sum_add;
  logic [63:0] fm;
  logic [48:0] dmag;
  logic [5:0]  rem6;
  logic        div_ge;
  logic signed [51:0] vj;

  assign in_range_now = {3'b000, dim_index_i} < DimsLimit;

  ardk_ram #(
    .WIDTH(32),
    .DEPTH(DIMS)
  ) u_weights (
    .clk_i  (clk_i),
    .we_i   ((cmd_i.op == ardk_pkg::OP_CAPTURE) && !command_i && in_range_now),
    .waddr_i(AW'(dim_index_i)),
    .wdata_i(weight_value_i),
    .re_i   (cmd_i.op == ardk_pkg::OP_CAPTURE),
    .raddr_i(AW'(dim_index_i)),
    .rdata_o(w)
  );

  assign dx_in = {first_coord_i[31], first_coord_i} - {second_coord_i[31], second_coord_i};
  assign dx_neg = -dx_in;

  assign a_part = (cmd_i.step == 2'd0 || cmd_i.step == 2'd1) ? a_q[31:0] : a_q[63:32];
  assign b_part = (cmd_i.step == 2'd0 || cmd_i.step == 2'd2) ? b_q[31:0] : b_q[63:32];
  assign pp = a_part * b_part;

  always_comb begin
    case (cmd_i.step)
      2'd0:    pp_shift = {64'd0, pp};
      2'd3:    pp_shift = {pp, 64'd0};
      default: pp_shift = {32'd0, pp, 32'd0};
    endcase
  end

  assign fm = dfac_q[63] ? 64'(-dfac_q) : 64'(dfac_q);
  assign rem6 = {rem_q, quo_q[63]};
  assign div_ge = rem6 >= {1'b0, k_q};

  always_comb begin
    mode_d = mode_q;
    deriv_dim_d = deriv_dim_q;
    jitter_d = jitter_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        ardk_pkg::CFG_MODE:      mode_d = cfg_wdata_i[0];
        ardk_pkg::CFG_DERIV_DIM: deriv_dim_d = cfg_wdata_i[3:0];
        ardk_pkg::CFG_JITTER:    jitter_d = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    sum_d = sum_q; dfac_d = dfac_q; clip_d = clip_q;
    cmd_d = cmd_q; last_d = last_q; diag_d = diag_q; dim_d = dim_q;
    dx_d = dx_q; mag_d = mag_q; a_d = a_q; b_d = b_q; prod_d = prod_q;
    t_d = t_q; pos_d = pos_q; neg_d = neg_q; e_d = e_q; p_d = p_q; quo_d = quo_q;
    f_d = f_q; n_d = n_q; k_d = k_q; rem_d = rem_q; ser_one_d = ser_one_q;
    val_d = val_q; kv_d = kv_q; sat_d = sat_q;
    sum_add = {1'b0, sum_q} + {1'b0, prod_q[87:24]};
    dmag = '0;
    vj = '0;
    case (cmd_i.op)
      ardk_pkg::OP_CAPTURE: begin
        cmd_d = command_i;
        dim_d = dim_index_i;
        last_d = last_dim_i;
        diag_d = on_diagonal_i;
        dx_d = dx_in;
        mag_d = dx_in[32] ? dx_neg[31:0] : dx_in[31:0];
      end
      ardk_pkg::OP_MUL_LOAD: begin
        prod_d = '0;
        case (cmd_i.sel)
          ardk_pkg::SEL_MAG_MAG: begin a_d = {32'd0, mag_q}; b_d = {32'd0, mag_q}; end
          ardk_pkg::SEL_SQ_W:    begin a_d = prod_q[63:0]; b_d = {32'd0, w}; end
          ardk_pkg::SEL_MAG_W:   begin a_d = {32'd0, mag_q}; b_d = {32'd0, w}; end
          ardk_pkg::SEL_T_F:     begin a_d = t_q; b_d = {31'd0, f_q}; end
          ardk_pkg::SEL_E_P:     begin a_d = e_q; b_d = p_q; end
          ardk_pkg::SEL_P_P:     begin a_d = p_q; b_d = p_q; end
          ardk_pkg::SEL_FM_E:    begin a_d = fm; b_d = e_q; end
          default:               begin a_d = '0; b_d = '0; end
        endcase
      end
      ardk_pkg::OP_MUL_STEP: prod_d = prod_q + pp_shift;
      ardk_pkg::OP_ACC: begin
        if ((prod_q[127:88] != '0) || sum_add[64]) begin
          sum_d = '1;
          clip_d = 1'b1;
        end else begin
          sum_d = sum_add[63:0];
        end
      end
      ardk_pkg::OP_DFAC: begin
        if (prod_q[63]) begin
          clip_d = 1'b1;
          dfac_d = (dx_q > 0) ? -64'sh7FFF_FFFF_FFFF_FFFF : 64'sh7FFF_FFFF_FFFF_FFFF;
        end else begin
          dfac_d = (dx_q > 0) ? -$signed(prod_q[63:0]) : $signed(prod_q[63:0]);
        end
      end
      ardk_pkg::OP_EZERO: e_d = '0;
      ardk_pkg::OP_SER_INIT: begin
        t_d = ardk_pkg::ONE62;
        pos_d = ardk_pkg::ONE62;
        neg_d = '0;
        k_d = 5'd1;
        ser_one_d = cmd_i.ser_one;
        f_d = cmd_i.ser_one ? {1'b1, 32'd0} : {1'b0, sum_q[31:0]};
        if (!cmd_i.ser_one) begin
          n_d = sum_q[36:32];
        end
      end
      ardk_pkg::OP_DIV_INIT: begin
        quo_d = prod_q[95:32];
        rem_d = '0;
      end
      ardk_pkg::OP_DIV_STEP: begin
        quo_d = {quo_q[62:0], div_ge};
        rem_d = div_ge ? 5'(rem6 - {1'b0, k_q}) : rem6[4:0];
      end
      ardk_pkg::OP_SER_ACC: begin
        t_d = quo_q;
        if (k_q[0]) neg_d = neg_q + quo_q;
        else pos_d = pos_q + quo_q;
        k_d = k_q + 5'd1;
      end
      ardk_pkg::OP_SER_END: begin
        if (ser_one_q) p_d = (pos_q >= neg_q) ? pos_q - neg_q : '0;
        else e_d = (pos_q >= neg_q) ? pos_q - neg_q : '0;
      end
      ardk_pkg::OP_E_UPD: e_d = prod_q[125:62];
      ardk_pkg::OP_P_UPD: begin
        p_d = prod_q[125:62];
        n_d = {1'b0, n_q[4:1]};
      end
      ardk_pkg::OP_ROUND: e_d = (e_q + 64'h2_0000) >> 18;
      ardk_pkg::OP_VAL_KERNEL: val_d = $signed({1'b0, e_q[49:0]});
      ardk_pkg::OP_VAL_DERIV: begin
        if (prod_q[127:103] != '0) begin
          dmag = {1'b1, 48'd0};
        end else if (prod_q[102:87] != '0) begin
          dmag = {1'b1, 48'd0};
        end else begin
          dmag = prod_q[87:39];
        end
        val_d = dfac_q[63] ? -$signed({2'b00, dmag}) : $signed({2'b00, dmag});
      end
      ardk_pkg::OP_FINAL: begin
        vj = {val_q[50], val_q} + (diag_q ? $signed({36'd0, jitter_q}) : 52'sd0);
        if (vj > OutMax) begin
          kv_d = OutMax[47:0];
          sat_d = 1'b1;
        end else if (vj < OutMin) begin
          kv_d = OutMin[47:0];
          sat_d = 1'b1;
        end else begin
          kv_d = vj[47:0];
          sat_d = clip_q;
        end
        sum_d = '0;
        dfac_d = '0;
        clip_d = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      deriv_dim_q <= 4'd0;
      jitter_q <= ardk_pkg::JITTER_RESET;
      sum_q <= '0;
      dfac_q <= '0;
      clip_q <= 1'b0;
    end else begin
      mode_q <= mode_d;
      deriv_dim_q <= deriv_dim_d;
      jitter_q <= jitter_d;
      sum_q <= sum_d;
      dfac_q <= dfac_d;
      clip_q <= clip_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; last_q <= last_d; diag_q <= diag_d; dim_q <= dim_d;
    dx_q <= dx_d; mag_q <= mag_d; a_q <= a_d; b_q <= b_d; prod_q <= prod_d;
    t_q <= t_d; pos_q <= pos_d; neg_q <= neg_d; e_q <= e_d; p_q <= p_d; quo_q <= quo_d;
    f_q <= f_d; n_q <= n_d; k_q <= k_d; rem_q <= rem_d; ser_one_q <= ser_one_d;
    val_q <= val_d; kv_q <= kv_d; sat_q <= sat_d;
  end

  assign status_o.cmd       = cmd_q;
  assign status_o.in_range  = {3'b000, dim_q} < DimsLimit;
  assign status_o.deriv_hit = dim_q == deriv_dim_q;
  assign status_o.last      = last_q;
  assign status_o.n_big     = sum_q[63:37] != '0;
  assign status_o.ser_one   = ser_one_q;
  assign status_o.k_last    = k_q == ardk_pkg::SERIES_TERMS;
  assign status_o.n_lsb     = n_q[0];
  assign status_o.mode      = mode_q;

  assign kernel_value_o = kv_q;
  assign saturated_o    = sat_q;

endmodule

### hdl/ardk_ctrl.sv
`timescale 1ns / 1ps

module ardk_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  ardk_pkg::dp_status_t status_i,
  output ardk_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [21:0] {
    S_IDLE      = 22'h000001,
    S_DECIDE    = 22'h000002,
    S_MUL_LOAD  = 22'h000004,
    S_MUL_STEP  = 22'h000008,
    S_SQW       = 22'h000010,
    S_ACC       = 22'h000020,
    S_DFAC      = 22'h000040,
    S_EXP_INIT  = 22'h000080,
    S_SER_MUL   = 22'h000100,
    S_DIV_INIT  = 22'h000200,
    S_DIV       = 22'h000400,
    S_SER_ACC   = 22'h000800,
    S_SER_END   = 22'h001000,
    S_SER2_INIT = 22'h002000,
    S_POW       = 22'h004000,
    S_EUPD      = 22'h008000,
    S_PSQ       = 22'h010000,
    S_PUPD      = 22'h020000,
    S_ROUND     = 22'h040000,
    S_KVAL      = 22'h080000,
    S_DERIV     = 22'h100000,
    S_FINAL     = 22'h200000
  } state_e;

  localparam logic [2:0] PowLast = 3'd4;

  state_e             state_q, state_d, ret_q, ret_d;
  ardk_pkg::mul_sel_e sel_q, sel_d;
  logic [1:0]         step_q, step_d;
  logic [5:0]         div_q, div_d;
  logic [2:0]         pow_q, pow_d;
  logic               out_valid_q, out_valid_d;
  logic               out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    ret_d = ret_q;
    sel_d = sel_q;
    step_d = step_q;
    div_d = div_q;
    pow_d = pow_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o.op = ardk_pkg::OP_NONE;
    cmd_o.sel = sel_q;
    cmd_o.step = step_q;
    cmd_o.ser_one = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = ardk_pkg::OP_CAPTURE;
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!status_i.cmd) begin
          state_d = S_IDLE;
        end else if (status_i.in_range) begin
          sel_d = ardk_pkg::SEL_MAG_MAG; ret_d = S_SQW; state_d = S_MUL_LOAD;
        end else if (status_i.last) begin
          state_d = S_EXP_INIT;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_MUL_LOAD: begin
        cmd_o.op = ardk_pkg::OP_MUL_LOAD;
        step_d = 2'd0;
        state_d = S_MUL_STEP;
      end
      S_MUL_STEP: begin
        cmd_o.op = ardk_pkg::OP_MUL_STEP;
        step_d = step_q + 2'd1;
        if (step_q == 2'd3) begin
          state_d = ret_q;
        end
      end
      S_SQW: begin
        sel_d = ardk_pkg::SEL_SQ_W; ret_d = S_ACC; state_d = S_MUL_LOAD;
      end
      S_ACC: begin
        cmd_o.op = ardk_pkg::OP_ACC;
        if (status_i.deriv_hit) begin
          sel_d = ardk_pkg::SEL_MAG_W; ret_d = S_DFAC; state_d = S_MUL_LOAD;
        end else begin
          state_d = status_i.last ? S_EXP_INIT : S_IDLE;
        end
      end
      S_DFAC: begin
        cmd_o.op = ardk_pkg::OP_DFAC;
        state_d = status_i.last ? S_EXP_INIT : S_IDLE;
      end
      S_EXP_INIT: begin
        if (status_i.n_big) begin
          cmd_o.op = ardk_pkg::OP_EZERO;
          state_d = S_ROUND;
        end else begin
          cmd_o.op = ardk_pkg::OP_SER_INIT;
          state_d = S_SER_MUL;
        end
      end
      S_SER_MUL: begin
        sel_d = ardk_pkg::SEL_T_F; ret_d = S_DIV_INIT; state_d = S_MUL_LOAD;
      end
      S_DIV_INIT: begin
        cmd_o.op = ardk_pkg::OP_DIV_INIT;
        div_d = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.op = ardk_pkg::OP_DIV_STEP;
        div_d = div_q + 6'd1;
        if (div_q == 6'd63) begin
          state_d = S_SER_ACC;
        end
      end
      S_SER_ACC: begin
        cmd_o.op = ardk_pkg::OP_SER_ACC;
        state_d = status_i.k_last ? S_SER_END : S_SER_MUL;
      end
      S_SER_END: begin
        cmd_o.op = ardk_pkg::OP_SER_END;
        pow_d = '0;
        state_d = status_i.ser_one ? S_POW : S_SER2_INIT;
      end
      S_SER2_INIT: begin
        cmd_o.op = ardk_pkg::OP_SER_INIT;
        cmd_o.ser_one = 1'b1;
        state_d = S_SER_MUL;
      end
      S_POW: begin
        if (status_i.n_lsb) begin
          sel_d = ardk_pkg::SEL_E_P; ret_d = S_EUPD; state_d = S_MUL_LOAD;
        end else begin
          state_d = S_PSQ;
        end
      end
      S_EUPD: begin
        cmd_o.op = ardk_pkg::OP_E_UPD;
        state_d = S_PSQ;
      end
      S_PSQ: begin
        sel_d = ardk_pkg::SEL_P_P; ret_d = S_PUPD; state_d = S_MUL_LOAD;
      end
      S_PUPD: begin
        cmd_o.op = ardk_pkg::OP_P_UPD;
        pow_d = pow_q + 3'd1;
        state_d = (pow_q == PowLast) ? S_ROUND : S_POW;
      end
      S_ROUND: begin
        cmd_o.op = ardk_pkg::OP_ROUND;
        if (status_i.mode) begin
          sel_d = ardk_pkg::SEL_FM_E; ret_d = S_DERIV; state_d = S_MUL_LOAD;
        end else begin
          state_d = S_KVAL;
        end
      end
      S_KVAL: begin
        cmd_o.op = ardk_pkg::OP_VAL_KERNEL;
        state_d = S_FINAL;
      end
      S_DERIV: begin
        cmd_o.op = ardk_pkg::OP_VAL_DERIV;
        state_d = S_FINAL;
      end
      S_FINAL: begin
        if (out_free) begin
          cmd_o.op = ardk_pkg::OP_FINAL;
          out_valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q <= S_IDLE;
      sel_q <= ardk_pkg::SEL_MAG_MAG;
      step_q <= '0;
      div_q <= '0;
      pow_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q <= ret_d;
      sel_q <= sel_d;
      step_q <= step_d;
      div_q <= div_d;
      pow_q <= pow_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;

  a_rise_from_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_FINAL)
    else $error("result raised outside the final state");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> state_q == S_DECIDE)
    else $error("input transfer did not start processing");

  a_step_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_MUL_STEP) |-> step_q == 2'd0)
    else $error("multiplier step count left nonzero");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SER_ACC) |-> div_q == 6'd0)
    else $error("division ended before all quotient bits");

endmodule

### dv/ard_rbf_kernel_checker.sv
`timescale 1ns / 1ps

package ardk_tb_pkg;

  typedef enum logic {
    CMD_LOAD_WEIGHT = 1'b0,
    CMD_COORD_PAIR  = 1'b1
  } item_cmd_e;

endpackage

module ard_rbf_kernel_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ardk_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ardk_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  logic                            command_i,
  input  logic [3:0]                      dim_index_i,
  input  logic signed [31:0]              first_coord_i,
  input  logic signed [31:0]              second_coord_i,
  input  logic [31:0]                     weight_value_i,
  input  logic                            last_dim_i,
  input  logic                            on_diagonal_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  logic signed [47:0]              kernel_value_i,
  input  logic                            saturated_i,
  output int                              fail_count_o,
  output int                              pending_o
);

  localparam longint KV_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint KV_MIN = -64'sh0000_8000_0000_0000;

  typedef struct packed {
    logic signed [47:0] value;
    logic               clipped;
  } kernel_entry_t;

  logic [31:0]        weight_mem [16];
  logic [63:0]        dist_sum = '0;
  logic signed [63:0] grad_factor = '0;
  logic               clip_flag = 1'b0;
  logic               mode_q = 1'b0;
  logic [3:0]         grad_dim_q = '0;
  logic [15:0]        jitter_q = ardk_pkg::JITTER_RESET;
  kernel_entry_t      kernel_q [$];
  kernel_entry_t      want;
  int                 fails = 0;
  int                 pend = 0;

  assign fail_count_o = fails;
  assign pending_o = pend;

  initial begin
    for (int i = 0; i < 16; i++) weight_mem[i] = '0;
  end

  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[125:62];
  endfunction

  // Alternating Taylor series for exp(-f), f in Q32.32 no larger than one, result Q2.62.
  function automatic logic [63:0] exp_taylor(input logic [63:0] f);
    logic [63:0]  pos;
    logic [63:0]  neg;
    logic [63:0]  t;
    logic [127:0] prod;
    pos = ardk_pkg::ONE62;
    neg = '0;
    t = ardk_pkg::ONE62;
    for (int k = 1; k <= 24; k++) begin
      prod = {64'd0, t} * {64'd0, f};
      t = prod[95:32] / 64'(k);
      if (k % 2 == 1) neg = neg + t;
      else pos = pos + t;
    end
    return (pos >= neg) ? pos - neg : 64'd0;
  endfunction

  function automatic logic [63:0] exp_decay(input logic [63:0] s);
    logic [63:0] e;
    logic [63:0] p;
    if (s[63:32] >= 32) return 64'd0;
    e = exp_taylor({32'd0, s[31:0]});
    p = exp_taylor(64'h1_0000_0000);
    for (int i = 0; i < 5; i++) begin
      if (s[32+i]) e = mul_q62(e, p);
      p = mul_q62(p, p);
    end
    return (e + 64'h2_0000) >> 18;
  endfunction

  task automatic absorb_item();
    longint       dx;
    logic [63:0]  mag;
    logic [63:0]  sq;
    logic [63:0]  prodw;
    logic [127:0] wide;
    logic [64:0]  sum_ext;
    logic [63:0]  e;
    logic [63:0]  fm;
    logic         negf;
    longint       val;
    kernel_entry_t res;
    if (command_i == ardk_tb_pkg::CMD_LOAD_WEIGHT) begin
      weight_mem[dim_index_i] = weight_value_i;
      return;
    end
    dx = longint'(first_coord_i) - longint'(second_coord_i);
    mag = (dx < 0) ? 64'(-dx) : 64'(dx);
    sq = mag * mag;
    wide = {64'd0, sq} * {96'd0, weight_mem[dim_index_i]};
    if (wide[127:88] != 0) begin
      dist_sum = '1;
      clip_flag = 1'b1;
    end else begin
      sum_ext = {1'b0, dist_sum} + {1'b0, wide[87:24]};
      if (sum_ext[64]) begin
        dist_sum = '1;
        clip_flag = 1'b1;
      end else begin
        dist_sum = sum_ext[63:0];
      end
    end
    if (dim_index_i == grad_dim_q) begin
      prodw = mag * {32'd0, weight_mem[dim_index_i]};
      if (prodw[63]) begin
        prodw = 64'h7FFF_FFFF_FFFF_FFFF;
        clip_flag = 1'b1;
      end
      grad_factor = (dx > 0) ? -$signed(prodw) : $signed(prodw);
    end
    if (!last_dim_i) return;
    e = exp_decay(dist_sum);
    if (!mode_q) begin
      val = longint'(e);
    end else begin
      negf = grad_factor < 0;
      fm = negf ? 64'(-grad_factor) : 64'(grad_factor);
      wide = {64'd0, fm} * {64'd0, e};
      if (wide[127:103] != 0) mag = 64'd1 << 48;
      else mag = wide[102:39];
      if (mag > (64'd1 << 48)) mag = 64'd1 << 48;
      val = negf ? -longint'(mag) : longint'(mag);
    end
    if (on_diagonal_i) val = val + longint'({48'd0, jitter_q});
    res.clipped = clip_flag;
    if (val > KV_MAX) begin
      val = KV_MAX;
      res.clipped = 1'b1;
    end
    if (val < KV_MIN) begin
      val = KV_MIN;
      res.clipped = 1'b1;
    end
    res.value = val[47:0];
    kernel_q.push_back(res);
    dist_sum = '0;
    grad_factor = '0;
    clip_flag = 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (ardk_pkg::cfg_index_e'(cfg_index_i))
          ardk_pkg::CFG_MODE:      mode_q = cfg_wdata_i[0];
          ardk_pkg::CFG_DERIV_DIM: grad_dim_q = cfg_wdata_i[3:0];
          ardk_pkg::CFG_JITTER:    jitter_q = cfg_wdata_i;
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (kernel_q.size() == 0) begin
          $display("%0t: unexpected result transfer, value %0d saturated %0b",
                   $time, kernel_value_i, saturated_i);
          fails++;
        end else begin
          want = kernel_q.pop_front();
          if (kernel_value_i !== want.value) begin
            $display("%0t: kernel_value expected %0d actual %0d",
                     $time, want.value, kernel_value_i);
            fails++;
          end
          if (saturated_i !== want.clipped) begin
            $display("%0t: saturated expected %0b actual %0b",
                     $time, want.clipped, saturated_i);
            fails++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) absorb_item();
      pend <= kernel_q.size();
    end
  end

endmodule

### dv/ard_rbf_kernel_engine_tb.sv
`timescale 1ns / 1ps

module ard_rbf_kernel_engine_tb;

  localparam int unsigned CYCLE_LIMIT = 10_000_000;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            cfg_we_i = 1'b0;
  logic [ardk_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [ardk_pkg::CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                            in_valid_i = 1'b0;
  logic                            in_stall_o;
  logic                            command_i = 1'b0;
  logic [3:0]                      dim_index_i = '0;
  logic signed [31:0]              first_coord_i = '0;
  logic signed [31:0]              second_coord_i = '0;
  logic [31:0]                     weight_value_i = '0;
  logic                            last_dim_i = 1'b0;
  logic                            on_diagonal_i = 1'b0;
  logic                            out_valid_o;
  logic                            out_stall_i = 1'b0;
  logic signed [47:0]              kernel_value_o;
  logic                            saturated_o;

  int          fail_count;
  int          pending;
  int unsigned cycles = 0;
  int unsigned stall_left = 0;
  int unsigned sent = 0;
  logic        calm = 1'b0;

  ard_rbf_kernel_engine dut (.*);

  ard_rbf_kernel_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .command_i      (command_i),
    .dim_index_i    (dim_index_i),
    .first_coord_i  (first_coord_i),
    .second_coord_i (second_coord_i),
    .weight_value_i (weight_value_i),
    .last_dim_i     (last_dim_i),
    .on_diagonal_i  (on_diagonal_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kernel_value_i (kernel_value_o),
    .saturated_i    (saturated_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (calm) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < 40);
      stall_left <= ($urandom_range(0, 99) < 5) ? $urandom_range(20, 120)
                                                 : $urandom_range(0, 3);
    end
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic push_item(input ardk_tb_pkg::item_cmd_e cmd, input logic [3:0] d,
                           input logic [31:0] a, input logic [31:0] b,
                           input logic [31:0] w, input logic last, input logic diag);
    int unsigned g;
    command_i <= cmd;
    dim_index_i <= d;
    first_coord_i <= a;
    second_coord_i <= b;
    weight_value_i <= w;
    last_dim_i <= last;
    on_diagonal_i <= diag;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent++;
    g = idle_len();
    if (g != 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(input ardk_pkg::cfg_index_e idx,
                           input logic [ardk_pkg::CFG_DATA_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_coord(input logic [3:0] d, input logic last);
    logic [31:0] a;
    logic [31:0] b;
    a = $urandom;
    if ($urandom_range(0, 99) < 85) b = a - ($urandom_range(0, 32'h4_0000) - 32'h2_0000);
    else b = $urandom;
    push_item(ardk_tb_pkg::CMD_COORD_PAIR, d, a, b, $urandom, last,
              $urandom_range(0, 3) == 0);
  endtask

  task automatic random_load();
    logic [31:0] w;
    if ($urandom_range(0, 99) < 85) w = $urandom_range(32'h0010_0000, 32'h0200_0000);
    else w = $urandom;
    push_item(ardk_tb_pkg::CMD_LOAD_WEIGHT, 4'($urandom_range(0, 15)), $urandom, $urandom,
              w, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  task automatic random_phase(input int unsigned count);
    int unsigned stop;
    int unsigned len;
    stop = sent + count;
    while (sent < stop) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(2, 6);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 99) < 15) random_load();
        random_coord(4'($urandom_range(0, 15)), i == len - 1);
      end
    end
  endtask

  initial begin
    logic [15:0] modes [6];
    logic [15:0] dims [6];
    logic [15:0] jits [6];
    modes = '{0, 1, 1, 0, 1, 1};
    dims = '{0, 15, 3, 7, 0, 16'($urandom_range(0, 15))};
    jits = '{0, 16'hFFFF, 1759, 16'hFFFF, 0, 16'($urandom_range(0, 16'hFFFF))};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int d = 0; d < 16; d++) begin
      push_item(ardk_tb_pkg::CMD_LOAD_WEIGHT, 4'(d), 0, 0,
                (d == 0) ? 32'h0 : (d == 1) ? 32'hFFFF_FFFF : 32'h0040_0000 << (d % 4),
                1'b0, 1'b0);
    end
    push_item(ardk_tb_pkg::CMD_COORD_PAIR, 4'd2, 0, 0, 0, 1'b1, 1'b0);
    push_item(ardk_tb_pkg::CMD_COORD_PAIR, 4'd1, 32'h8000_0000, 32'h7FFF_FFFF, 0, 1'b1, 1'b0);
    push_item(ardk_tb_pkg::CMD_COORD_PAIR, 4'd0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 1'b1, 1'b1);
    push_item(ardk_tb_pkg::CMD_LOAD_WEIGHT, 4'd5, 0, 0, 32'h0100_0000, 1'b1, 1'b1);
    push_item(ardk_tb_pkg::CMD_COORD_PAIR, 4'd3, 32'h0001_0000, 32'hFFFF_0000, 0, 1'b0, 1'b0);
    push_item(ardk_tb_pkg::CMD_COORD_PAIR, 4'd4, 32'h0002_0000, 32'h0, 0, 1'b1, 1'b1);
    push_item(ardk_tb_pkg::CMD_COORD_PAIR, 4'd3, 32'h4000_0000, 32'hC000_0000, 0, 1'b1, 1'b0);
    random_phase(60);

    for (int p = 0; p < 6; p++) begin
      wait_idle();
      calm = (p == 2);
      write_reg(ardk_pkg::CFG_MODE, modes[p]);
      write_reg(ardk_pkg::CFG_DERIV_DIM, dims[p]);
      write_reg(ardk_pkg::CFG_JITTER, jits[p]);
      // Extreme weight and span on the chosen dimension push the factor and the
      // output into saturation, then a sane weight is restored.
      push_item(ardk_tb_pkg::CMD_LOAD_WEIGHT, dims[p][3:0], 0, 0, 32'hFFFF_FFFF,
                1'b0, 1'b0);
      push_item(ardk_tb_pkg::CMD_COORD_PAIR, dims[p][3:0], 32'h8000_0000, 32'h7FFF_FFFF, 0,
                1'b1, 1'b1);
      push_item(ardk_tb_pkg::CMD_LOAD_WEIGHT, dims[p][3:0], 0, 0, 32'h0080_0000,
                1'b0, 1'b0);
      push_item(ardk_tb_pkg::CMD_COORD_PAIR, dims[p][3:0], 32'h0000_8000, 32'hFFFF_C000, 0,
                1'b1, 1'b1);
      random_phase(120);
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### files.f
hdl/ardk_pkg.sv
hdl/ardk_ram.sv
hdl/ardk_datapath.sv
hdl/ardk_ctrl.sv
hdl/ard_rbf_kernel_engine.sv
dv/ard_rbf_kernel_checker.sv
dv/ard_rbf_kernel_engine_tb.sv
